// ===== design/rpdf_pkg.sv =====
package rpdf_pkg;

  localparam int DIST_W   = 25;
  localparam int SQ_W     = 2 * DIST_W;
  localparam int REQ_W    = 2;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [DIST_W-1:0] MAX_DIST_RESET = 25'd23726566;

  // request kinds carried on in_tuser
  localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  // result status carried on out_tuser
  localparam logic [STATUS_W-1:0] STAT_LOAD_OK = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_MATCH   = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NONE    = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_ENABLE = 1'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RESP,
    ST_MD,
    ST_RD,
    ST_DX,
    ST_DY,
    ST_SUM,
    ST_SQRT,
    ST_EMIT,
    ST_FIN
  } state_t;

endpackage

// ===== design/rpdf_isqrt.sv =====
module rpdf_isqrt
  import rpdf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SQ_W-1:0]   value,
  output logic              busy,
  output logic [DIST_W-1:0] root
);

  localparam logic [SQ_W-1:0] BIT_INIT = SQ_W'(1) << (SQ_W - 2);

  logic            busy_r;
  logic [SQ_W-1:0] n_r;
  logic [SQ_W-1:0] res_r;
  logic [SQ_W-1:0] bit_r;
  logic [SQ_W:0]   trial;
  logic            take;

  // one result bit per cycle, restoring form
  assign trial = {1'b0, res_r} + {1'b0, bit_r};
  assign take  = {1'b0, n_r} >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && bit_r[0]) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= value;
      res_r <= '0;
      bit_r <= BIT_INIT;
    end else if (busy_r) begin
      if (take) begin
        n_r   <= n_r - trial[SQ_W-1:0];
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign busy = busy_r;
  assign root = res_r[DIST_W-1:0];

endmodule

// ===== design/radius_point_distance_filter.sv =====
// Load and clear: one result, via ST_RESP and the output register, once the output slot is free.
// Query: square the cutoff in ST_MD, then ST_RD, ST_DX, ST_DY and ST_SUM for each stored
// target, plus ST_SQRT and ST_EMIT for each reported target (25-step square
// root on a single shared unit, plus a single shared multiplier), then ST_FIN.
// One item at a time; in_tready is high only between items.
// Reset (synchronous, rst_n low) empties the table and restores the cutoff.
module radius_point_distance_filter
  import rpdf_pkg::*;
#(
  parameter int TARGET_DEPTH = 64,
  parameter int COORD_WIDTH  = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // coord_x, coord_y
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  // req_type
  input  logic [REQ_W-1:0]     in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // target_x, target_y, distance
  output logic [((2*COORD_WIDTH+DIST_W+7)/8)*8-1:0] out_tdata,
  // status
  output logic [STATUS_W-1:0]  out_tuser,
  output logic                 out_tlast,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [DIST_W-1:0]    cfg_wdata
);

  localparam int W          = COORD_WIDTH;
  localparam int OUT_DATA_W = ((2*W+DIST_W+7)/8)*8;
  localparam int IDX_W      = (TARGET_DEPTH > 1) ? $clog2(TARGET_DEPTH) : 1;
  localparam int CNT_W      = $clog2(TARGET_DEPTH + 1);
  localparam int MUL_W      = (W > DIST_W) ? W : DIST_W;
  localparam int SUM_W      = 2*W + 1;
  localparam int EXT_W      = (SUM_W > SQ_W) ? SUM_W : SQ_W;
  localparam logic [SQ_W-1:0] SQ_MAX = '1;

  state_t state_r, state_nxt;

  logic [DIST_W-1:0] max_dist_r;
  logic              cut_en_r;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  logic              out_valid_r;

  logic [W-1:0]      x_r, y_r;
  logic [2*W-1:0]    tgt_mem [TARGET_DEPTH];
  logic [W-1:0]      rd_x_r, rd_y_r;
  logic [SQ_W-1:0]   md_sq_r;
  logic [2*MUL_W-1:0] prod_r;
  logic [2*W-1:0]    sx_r;
  logic [STATUS_W-1:0] resp_status_r, resp_status_nxt;

  logic [W-1:0]      pend_x_r, pend_y_r;
  logic [DIST_W-1:0] pend_dist_r;

  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [W-1:0]      out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic [DIST_W-1:0] out_dist_r, out_dist_nxt;
  logic              out_last_r, out_last_nxt;

  logic              in_fire, slot_free;
  logic              mem_we, md_load, prod_load, sx_load, pend_load, out_load, sq_start;
  logic [MUL_W-1:0]  mul_op;
  logic [2*MUL_W-1:0] product;
  logic [W:0]        diff_x, diff_y, neg_x, neg_y;
  logic [W-1:0]      dx, dy;
  logic [SUM_W-1:0]  s_sum;
  logic [EXT_W-1:0]  s_ext;
  logic [SQ_W-1:0]   sq_in;
  logic              hit, more;
  logic              sq_busy;
  logic [DIST_W-1:0] sq_root;

  assign in_fire   = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);

  // absolute coordinate differences against the target read out of the table
  assign diff_x = {x_r[W-1], x_r} - {rd_x_r[W-1], rd_x_r};
  assign diff_y = {y_r[W-1], y_r} - {rd_y_r[W-1], rd_y_r};
  assign neg_x  = -diff_x;
  assign neg_y  = -diff_y;
  assign dx     = diff_x[W] ? neg_x[W-1:0] : diff_x[W-1:0];
  assign dy     = diff_y[W] ? neg_y[W-1:0] : diff_y[W-1:0];

  assign product = mul_op * mul_op;

  // sums at or above 2^50 give a distance that saturates anyway
  assign s_sum = SUM_W'(sx_r) + SUM_W'(prod_r[2*W-1:0]);
  assign s_ext = EXT_W'(s_sum);
  assign sq_in = (s_ext > EXT_W'(SQ_MAX)) ? SQ_MAX : s_ext[SQ_W-1:0];
  assign hit   = !cut_en_r || (s_ext <= EXT_W'(md_sq_r));
  assign more  = (CNT_W'(idx_r) + CNT_W'(1)) != count_r;

  rpdf_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .value (sq_in),
    .busy  (sq_busy),
    .root  (sq_root)
  );

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    idx_nxt         = idx_r;
    pend_valid_nxt  = pend_valid_r;
    resp_status_nxt = resp_status_r;
    mem_we          = 1'b0;
    md_load         = 1'b0;
    prod_load       = 1'b0;
    sx_load         = 1'b0;
    pend_load       = 1'b0;
    out_load        = 1'b0;
    sq_start        = 1'b0;
    mul_op          = MUL_W'(dx);
    out_status_nxt  = STAT_NONE;
    out_x_nxt       = '0;
    out_y_nxt       = '0;
    out_dist_nxt    = '0;
    out_last_nxt    = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_tuser)
            REQ_LOAD: begin
              if (count_r != CNT_W'(TARGET_DEPTH)) begin
                mem_we          = 1'b1;
                count_nxt       = count_r + CNT_W'(1);
                resp_status_nxt = STAT_LOAD_OK;
              end else begin
                resp_status_nxt = STAT_FULL;
              end
              state_nxt = ST_RESP;
            end
            REQ_CLEAR: begin
              count_nxt       = '0;
              resp_status_nxt = STAT_NONE;
              state_nxt       = ST_RESP;
            end
            REQ_QUERY: begin
              if (count_r == '0) begin
                resp_status_nxt = STAT_NONE;
                state_nxt       = ST_RESP;
              end else begin
                state_nxt = ST_MD;
              end
            end
            REQ_UNUSED: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_RESP: begin
        if (slot_free) begin
          out_load       = 1'b1;
          out_status_nxt = resp_status_r;
          state_nxt      = ST_IDLE;
        end
      end
      ST_MD: begin
        mul_op         = MUL_W'(max_dist_r);
        md_load        = 1'b1;
        idx_nxt        = '0;
        pend_valid_nxt = 1'b0;
        state_nxt      = ST_RD;
      end
      ST_RD: begin
        state_nxt = ST_DX;
      end
      ST_DX: begin
        mul_op    = MUL_W'(dx);
        prod_load = 1'b1;
        state_nxt = ST_DY;
      end
      ST_DY: begin
        sx_load   = 1'b1;
        mul_op    = MUL_W'(dy);
        prod_load = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        if (hit) begin
          sq_start  = 1'b1;
          state_nxt = ST_SQRT;
        end else if (more) begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = ST_RD;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_SQRT: begin
        if (!sq_busy) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // a held match goes out only once a later one proves it is not last
        if (!pend_valid_r || slot_free) begin
          if (pend_valid_r) begin
            out_load       = 1'b1;
            out_status_nxt = STAT_MATCH;
            out_x_nxt      = pend_x_r;
            out_y_nxt      = pend_y_r;
            out_dist_nxt   = pend_dist_r;
            out_last_nxt   = 1'b0;
          end
          pend_load      = 1'b1;
          pend_valid_nxt = 1'b1;
          if (more) begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = ST_RD;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          out_load = 1'b1;
          if (pend_valid_r) begin
            out_status_nxt = STAT_MATCH;
            out_x_nxt      = pend_x_r;
            out_y_nxt      = pend_y_r;
            out_dist_nxt   = pend_dist_r;
          end
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      idx_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      max_dist_r   <= MAX_DIST_RESET;
      cut_en_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      idx_r        <= idx_nxt;
      pend_valid_r <= pend_valid_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_MAX_DISTANCE:  max_dist_r <= cfg_wdata;
          CFG_CUTOFF_ENABLE: cut_en_r   <= cfg_wdata[0];
        endcase
      end
    end
  end

  // target table
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tgt_mem[count_r[IDX_W-1:0]] <= in_tdata[2*W-1:0];
    end
    {rd_y_r, rd_x_r} <= tgt_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    resp_status_r <= resp_status_nxt;
    if (in_fire) begin
      x_r <= in_tdata[W-1:0];
      y_r <= in_tdata[2*W-1:W];
    end
    if (md_load) begin
      md_sq_r <= product[SQ_W-1:0];
    end
    if (prod_load) begin
      prod_r <= product;
    end
    if (sx_load) begin
      sx_r <= prod_r[2*W-1:0];
    end
    if (pend_load) begin
      pend_x_r    <= rd_x_r;
      pend_y_r    <= rd_y_r;
      pend_dist_r <= sq_root;
    end
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_x_r      <= out_x_nxt;
      out_y_r      <= out_y_nxt;
      out_dist_r   <= out_dist_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({out_dist_r, out_y_r, out_x_r});
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule
